/* rtl/assert_macros.svh */
// Assertion macros used by the serializer bit engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define ALS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("als assertion failed");
// Condition that must never be seen on a clock edge outside reset.
`define ALS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("als forbidden condition seen");
`else
`define ALS_ASSERT(label, clk, rst_n, prop)
`define ALS_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/als_pkg.sv */
// Types, constants and helpers shared by the LED serializer modules.
`default_nettype none
package als_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int PIXEL_BITS  = 24;
    localparam int COLOR_BITS  = 24;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int BITS_LEFT_W = $clog2(PIXEL_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW = 3'd4;

    // Reset values: 350 ns, 800 ns, 700 ns, 600 ns and 300 us at a 10 ns tick.
    localparam logic [CFG_WIDTH-1:0] RST_ZERO_HIGH = 16'd35;
    localparam logic [CFG_WIDTH-1:0] RST_ZERO_LOW  = 16'd80;
    localparam logic [CFG_WIDTH-1:0] RST_ONE_HIGH  = 16'd70;
    localparam logic [CFG_WIDTH-1:0] RST_ONE_LOW   = 16'd60;
    localparam logic [CFG_WIDTH-1:0] RST_LATCH_LOW = 16'd30000;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    // One classified word as it travels through the queue.
    typedef struct packed {
        logic                  is_pixel;
        logic [PIXEL_BITS-1:0] pixel;
    } als_word_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] zero_high;
        logic [CFG_WIDTH-1:0] zero_low;
        logic [CFG_WIDTH-1:0] one_high;
        logic [CFG_WIDTH-1:0] one_low;
        logic [CFG_WIDTH-1:0] latch_low;
    } als_cfg_t;

    // A zero duration counts as one tick; a duration beyond the counter saturates.
    function automatic logic [COUNT_WIDTH-1:0] load_duration(input logic [CFG_WIDTH-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
        begin
            return COUNT_WIDTH'(1);
        end
        if (wide > 32'(COUNT_MAX))
        begin
            return COUNT_MAX;
        end
        return COUNT_WIDTH'(wide);
    endfunction

endpackage
`default_nettype wire

/* rtl/als_front.sv */
// Front end: takes input words, classifies them and packs pixels for the queue.
`default_nettype none
module als_front (
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                req_type,
    input  wire logic [7:0]          red,
    input  wire logic [7:0]          green,
    input  wire logic [7:0]          blue,
    input  wire logic                q_full,
    output logic                     q_push,
    output als_pkg::als_word_t       q_word
);

    logic [als_pkg::PIXEL_BITS-1:0] packed_pixel;

    // Green goes out first, so it sits at the top; spare frame bits trail as zeros.
    assign packed_pixel = als_pkg::PIXEL_BITS'({green, red, blue})
                          << (als_pkg::PIXEL_BITS - als_pkg::COLOR_BITS);

    always_comb
    begin
        q_word.is_pixel = req_type;
        q_word.pixel    = req_type ? packed_pixel : '0;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

/* rtl/als_queue.sv */
// Short word queue between the front end and the bit engine.
`default_nettype none
module als_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire als_pkg::als_word_t wr_word,
    input  wire logic               pop,
    output als_pkg::als_word_t      rd_word,
    output logic                    rd_valid,
    output logic                    full
);

    als_pkg::als_word_t                slot_reg [als_pkg::QUEUE_DEPTH];
    logic [als_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [als_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [als_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_pop;

    assign full     = (count_reg == als_pkg::QCNT_W'(als_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_word  = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule
`default_nettype wire

/* rtl/als_back.sv */
// Bit engine: runs line timing one word per cycle unless stalled; holds the result.
`default_nettype none
`include "assert_macros.svh"
module als_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire als_pkg::als_word_t           q_word,
    input  wire logic                         q_valid,
    output logic                              q_pop,
    input  wire logic                         cfg_wr_en,
    input  wire logic [als_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [als_pkg::CFG_WIDTH-1:0] cfg_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              line_level,
    output logic                              busy_res,
    output logic                              pixel_rejected
);

    als_pkg::als_cfg_t                      cfg_reg;
    als_pkg::phase_t                        phase_reg, phase_next;
    logic [als_pkg::PIXEL_BITS-1:0]         shifter_reg, shifter_next;
    logic [als_pkg::BITS_LEFT_W-1:0]        bits_left_reg, bits_left_next;
    logic [als_pkg::COUNT_WIDTH-1:0]        tick_count_reg, tick_count_next;
    logic [als_pkg::COUNT_WIDTH-1:0]        tick_dec;
    logic                                   out_valid_reg, out_valid_next;
    logic                                   line_reg, busy_reg, rejected_reg;
    logic                                   rejected;
    logic                                   load_pixel;
    logic                                   phase_done;
    logic                                   cur_bit;
    logic                                   following_bit;

    // A word leaves the queue whenever the result register is free or being taken.
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    assign load_pixel    = q_word.is_pixel && (phase_reg == als_pkg::PH_IDLE);
    assign rejected      = q_word.is_pixel && (phase_reg != als_pkg::PH_IDLE);
    assign tick_dec      = (tick_count_reg != '0) ? tick_count_reg - 1'b1 : '0;
    assign phase_done    = !q_word.is_pixel && (tick_dec == '0);
    assign cur_bit       = shifter_reg[als_pkg::PIXEL_BITS-1];
    assign following_bit = shifter_reg[als_pkg::PIXEL_BITS-2];

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            als_pkg::PH_IDLE:
            begin
                if (load_pixel)
                begin
                    phase_next = als_pkg::PH_HIGH;
                end
            end
            als_pkg::PH_HIGH:
            begin
                if (phase_done)
                begin
                    phase_next = als_pkg::PH_LOW;
                end
            end
            als_pkg::PH_LOW:
            begin
                if (phase_done)
                begin
                    phase_next = (bits_left_reg != '0) ? als_pkg::PH_HIGH
                                                       : als_pkg::PH_LATCH;
                end
            end
            als_pkg::PH_LATCH:
            begin
                if (phase_done)
                begin
                    phase_next = als_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = als_pkg::PH_IDLE;
            end
        endcase
    end

    // Shifter, bit count and phase timer.
    always_comb
    begin
        shifter_next    = shifter_reg;
        bits_left_next  = bits_left_reg;
        tick_count_next = tick_count_reg;
        unique case (phase_reg)
            als_pkg::PH_IDLE:
            begin
                if (load_pixel)
                begin
                    shifter_next    = q_word.pixel;
                    bits_left_next  = als_pkg::BITS_LEFT_W'(als_pkg::PIXEL_BITS - 1);
                    tick_count_next = als_pkg::load_duration(
                        q_word.pixel[als_pkg::PIXEL_BITS-1] ? cfg_reg.one_high
                                                            : cfg_reg.zero_high);
                end
            end
            als_pkg::PH_HIGH:
            begin
                if (!q_word.is_pixel)
                begin
                    tick_count_next = phase_done
                        ? als_pkg::load_duration(cur_bit ? cfg_reg.one_low
                                                         : cfg_reg.zero_low)
                        : tick_dec;
                end
            end
            als_pkg::PH_LOW:
            begin
                if (!q_word.is_pixel)
                begin
                    tick_count_next = tick_dec;
                    if (phase_done && (bits_left_reg != '0))
                    begin
                        bits_left_next  = bits_left_reg - 1'b1;
                        shifter_next    = shifter_reg << 1;
                        tick_count_next = als_pkg::load_duration(
                            following_bit ? cfg_reg.one_high : cfg_reg.zero_high);
                    end
                    else if (phase_done)
                    begin
                        tick_count_next = als_pkg::load_duration(cfg_reg.latch_low);
                    end
                end
            end
            als_pkg::PH_LATCH:
            begin
                if (!q_word.is_pixel)
                begin
                    tick_count_next = tick_dec;
                    if (phase_done)
                    begin
                        shifter_next = '0;
                    end
                end
            end
            default:
            begin
                shifter_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= als_pkg::PH_IDLE;
            shifter_reg    <= '0;
            bits_left_reg  <= '0;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                shifter_reg    <= shifter_next;
                bits_left_reg  <= bits_left_next;
                tick_count_reg <= tick_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            line_reg     <= (phase_next == als_pkg::PH_HIGH);
            busy_reg     <= (phase_next != als_pkg::PH_IDLE);
            rejected_reg <= rejected;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high <= als_pkg::RST_ZERO_HIGH;
            cfg_reg.zero_low  <= als_pkg::RST_ZERO_LOW;
            cfg_reg.one_high  <= als_pkg::RST_ONE_HIGH;
            cfg_reg.one_low   <= als_pkg::RST_ONE_LOW;
            cfg_reg.latch_low <= als_pkg::RST_LATCH_LOW;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                als_pkg::CFG_ZERO_HIGH: cfg_reg.zero_high <= cfg_data;
                als_pkg::CFG_ZERO_LOW:  cfg_reg.zero_low  <= cfg_data;
                als_pkg::CFG_ONE_HIGH:  cfg_reg.one_high  <= cfg_data;
                als_pkg::CFG_ONE_LOW:   cfg_reg.one_low   <= cfg_data;
                als_pkg::CFG_LATCH_LOW: cfg_reg.latch_low <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_level     = line_reg;
    assign busy_res       = busy_reg;
    assign pixel_rejected = rejected_reg;

    // An active phase always has time left on its timer.
    `ALS_ASSERT(a_timer_live, clk, rst_n, (phase_reg != als_pkg::PH_IDLE) |-> tick_count_reg != '0)
    // The shifter is empty whenever the engine is idle.
    `ALS_ASSERT(a_idle_clear, clk, rst_n, (phase_reg == als_pkg::PH_IDLE) |-> (shifter_reg == '0))
    // A dropped pixel can only be reported while the line is busy.
    `ALS_NEVER(a_reject_busy, clk, rst_n, out_valid_reg && rejected_reg && !busy_reg)
    // A word popped from the queue shows up as a result on the next cycle.
    `ALS_ASSERT(a_pop_result, clk, rst_n, q_pop |=> out_valid_reg)

endmodule
`default_nettype wire

/* rtl/addressable_led_serializer.sv */
// Top level of the single-wire addressable LED serializer.
// Each input word is either one clock tick of line time or a pixel (green, red, blue,
// sent MSB first); every word yields one result word with the line level, a busy flag
// and a flag for a pixel dropped because a frame was still running. The front end
// accepts a word every cycle into a four-entry queue while not full, and the bit
// engine retires one word per cycle from it into a result register unless out_stall
// holds it. The user must write bit timing registers through the cfg port while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module addressable_led_serializer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [7:0]                    red,
    input  wire logic [7:0]                    green,
    input  wire logic [7:0]                    blue,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               line_level,
    output logic                               busy_res,
    output logic                               pixel_rejected,
    input  wire logic                          cfg_wr_en,
    input  wire logic [als_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [als_pkg::CFG_WIDTH-1:0] cfg_data
);

    als_pkg::als_word_t push_word;
    als_pkg::als_word_t head_word;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_valid;

    als_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    als_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_word  (push_word),
        .pop      (q_pop),
        .rd_word  (head_word),
        .rd_valid (q_valid),
        .full     (q_full)
    );

    als_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_word         (head_word),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_level     (line_level),
        .busy_res       (busy_res),
        .pixel_rejected (pixel_rejected)
    );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LED serializer: bit timing, latch hold, dropped pixels.
module tb_top;
    import als_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_ITEMS    = 1300;
    localparam int LATENCY_PAD    = 4;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REG_SLOTS      = 2 ** CFG_IDX_W;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [CFG_WIDTH-1:0] TICKS_MAX = {CFG_WIDTH{1'b1}};

    typedef struct packed {
        logic level;
        logic busy;
        logic rejected;
    } line_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_TICK;
    logic [7:0]           red = 8'h00;
    logic [7:0]           green = 8'h00;
    logic [7:0]           blue = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 line_level;
    logic                 busy_res;
    logic                 pixel_rejected;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ZERO_HIGH;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    // Expected line state, kept in step with every accepted word.
    logic [CFG_WIDTH-1:0]   zero_high_cfg = 16'd35;
    logic [CFG_WIDTH-1:0]   zero_low_cfg = 16'd80;
    logic [CFG_WIDTH-1:0]   one_high_cfg = 16'd70;
    logic [CFG_WIDTH-1:0]   one_low_cfg = 16'd60;
    logic [CFG_WIDTH-1:0]   latch_cfg = 16'd30000;
    logic [PIXEL_BITS-1:0]  shift_reg = '0;
    int                     bits_to_go = 0;
    phase_t                 model_phase = PH_IDLE;
    logic [COUNT_WIDTH-1:0] ticks_left = '0;

    line_result_t expected_q[$];

    bit send_jitter = 1'b0;
    bit recv_jitter = 1'b0;
    int fail_count = 0;
    int results_checked = 0;
    int frames_started = 0;
    int pixels_dropped = 0;
    int busy_ticks = 0;
    int idle_ticks = 0;
    int idle_cycles = 0;

    addressable_led_serializer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_level     (line_level),
        .busy_res       (busy_res),
        .pixel_rejected (pixel_rejected),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A zero duration counts as a single tick.
    function automatic logic [COUNT_WIDTH-1:0] hold_ticks(input logic [CFG_WIDTH-1:0] v);
        return (v == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(v);
    endfunction

    function automatic void begin_high();
        model_phase = PH_HIGH;
        ticks_left = hold_ticks(shift_reg[PIXEL_BITS-1] ? one_high_cfg : zero_high_cfg);
    endfunction

    // Every accepted word lands in exactly one of these counts.
    function automatic int items_accepted();
        return frames_started + pixels_dropped + busy_ticks + idle_ticks;
    endfunction

    function automatic line_result_t advance_line(input logic req, input logic [7:0] r_val,
                                                  input logic [7:0] g_val,
                                                  input logic [7:0] b_val);
        line_result_t res;
        res.rejected = 1'b0;
        if (req == REQ_PIXEL)
        begin
            if (model_phase == PH_IDLE)
            begin
                shift_reg = PIXEL_BITS'({g_val, r_val, b_val}) << (PIXEL_BITS - COLOR_BITS);
                bits_to_go = PIXEL_BITS - 1;
                begin_high();
                frames_started++;
            end
            else
            begin
                res.rejected = 1'b1;
                pixels_dropped++;
            end
        end
        else if (model_phase != PH_IDLE)
        begin
            busy_ticks++;
            if (ticks_left != '0)
                ticks_left--;
            // The tick that ends a phase already shows the level of the next one.
            if (ticks_left == '0)
            begin
                case (model_phase)
                    PH_HIGH:
                    begin
                        model_phase = PH_LOW;
                        ticks_left = hold_ticks(shift_reg[PIXEL_BITS-1] ? one_low_cfg
                                                                         : zero_low_cfg);
                    end
                    PH_LOW:
                    begin
                        if (bits_to_go != 0)
                        begin
                            bits_to_go--;
                            shift_reg = shift_reg << 1;
                            begin_high();
                        end
                        else
                        begin
                            model_phase = PH_LATCH;
                            ticks_left = hold_ticks(latch_cfg);
                        end
                    end
                    default:
                    begin
                        model_phase = PH_IDLE;
                        shift_reg = '0;
                    end
                endcase
            end
        end
        else
        begin
            idle_ticks++;
        end
        res.level = (model_phase == PH_HIGH);
        res.busy = (model_phase != PH_IDLE);
        return res;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] rand_ticks(input int longest);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_WIDTH'(1);
            2: return CFG_WIDTH'($urandom_range(8, longest));
            default: return CFG_WIDTH'($urandom_range(1, 4));
        endcase
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin : check_results
        line_result_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result word with none expected: level %0b busy %0b rej %0b",
                             $time, line_level, busy_res, pixel_rejected);
                    fail_count++;
                end
                else
                begin
                    due = expected_q.pop_front();
                    if (line_level !== due.level)
                    begin
                        $display("%0t: line_level expected %0b, got %0b",
                                 $time, due.level, line_level);
                        fail_count++;
                    end
                    if (busy_res !== due.busy)
                    begin
                        $display("%0t: busy_res expected %0b, got %0b",
                                 $time, due.busy, busy_res);
                        fail_count++;
                    end
                    if (pixel_rejected !== due.rejected)
                    begin
                        $display("%0t: pixel_rejected expected %0b, got %0b",
                                 $time, due.rejected, pixel_rejected);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(advance_line(req_type, red, green, blue));
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    always
    begin
        @(negedge clk);
        if (recv_jitter && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            repeat (pause_len()) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // All tasks below start and end at a falling edge.
    task automatic send_word(input logic req, input logic [7:0] r_val, input logic [7:0] g_val,
                             input logic [7:0] b_val);
        int gap;
        gap = (send_jitter && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        red <= r_val;
        green <= g_val;
        blue <= b_val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    task automatic run_until_idle();
        while (model_phase != PH_IDLE)
            send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ZERO_HIGH: zero_high_cfg = val;
            CFG_ZERO_LOW:  zero_low_cfg = val;
            CFG_ONE_HIGH:  one_high_cfg = val;
            CFG_ONE_LOW:   one_low_cfg = val;
            CFG_LATCH_LOW: latch_cfg = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_timing(input logic [CFG_WIDTH-1:0] zero_high,
                               input logic [CFG_WIDTH-1:0] zero_low,
                               input logic [CFG_WIDTH-1:0] one_high,
                               input logic [CFG_WIDTH-1:0] one_low,
                               input logic [CFG_WIDTH-1:0] latch_low);
        settle();
        write_reg(CFG_ZERO_HIGH, zero_high);
        write_reg(CFG_ZERO_LOW, zero_low);
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ONE_LOW, one_low);
        write_reg(CFG_LATCH_LOW, latch_low);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes to unused indexes must leave the reset timing alone; the next test checks it.
    task automatic test_ignored_writes();
        settle();
        for (int idx = CFG_LATCH_LOW + 1; idx < REG_SLOTS; idx++)
        begin
            write_reg(CFG_IDX_W'(idx), TICKS_MAX);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // The first frame runs on reset timing through a one bit and into the low half of a
    // zero bit; shorter timing then finishes the frame so the latch hold stays brief.
    task automatic test_reset_timing();
        send_jitter = 1'b1;
        recv_jitter = 1'b1;
        send_word(REQ_TICK, 8'hFF, 8'hFF, 8'hFF);
        send_word(REQ_PIXEL, 8'h3C, 8'hA5, 8'h0F);
        send_word(REQ_PIXEL, 8'hFF, 8'h00, 8'hFF);
        repeat (170) send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
        load_timing(16'd2, 16'd1, 16'd1, 16'd2, 16'd3);
        run_until_idle();
    endtask

    task automatic test_minimum_timing();
        load_timing('0, '0, '0, '0, '0);
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00);
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        // Dropped on the very first word of the frame.
        send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        run_until_idle();
        send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        run_until_idle();
        load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_word(REQ_PIXEL, 8'h55, 8'hAA, 8'h0F);
        repeat (7) send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        while (model_phase != PH_LATCH)
            send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        run_until_idle();
        // A pixel right behind the end of the latch hold starts a new frame.
        send_word(REQ_PIXEL, 8'h80, 8'h01, 8'h80);
        run_until_idle();
    endtask

    // Counts above eight bits on the zero timing.
    task automatic test_long_zero_bits();
        send_jitter = 1'b0;
        recv_jitter = 1'b0;
        load_timing(16'd260, 16'd2, '0, '0, 16'd1);
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFE);
        run_until_idle();
    endtask

    // Counts above eight bits on the one timing.
    task automatic test_long_one_bits();
        send_jitter = 1'b0;
        recv_jitter = 1'b0;
        load_timing('0, 16'd1, 16'd260, 16'd2, 16'd1);
        send_word(REQ_PIXEL, 8'h10, 8'h00, 8'h00);
        run_until_idle();
    endtask

    task automatic test_random_traffic();
        while (items_accepted() < TOTAL_ITEMS)
        begin
            send_jitter = ($urandom_range(0, 3) != 0);
            recv_jitter = ($urandom_range(0, 3) != 0);
            load_timing(rand_ticks(12), rand_ticks(12), rand_ticks(12), rand_ticks(12),
                        rand_ticks(40));
            repeat ($urandom_range(1, 3))
            begin
                if (items_accepted() < TOTAL_ITEMS)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
                    send_word(REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
                    while (model_phase != PH_IDLE)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            send_word(REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
                        else
                            send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte());
                        if ($urandom_range(0, 99) == 0)
                            hold_until_drained();
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_ignored_writes();
        test_reset_timing();
        test_minimum_timing();
        test_long_zero_bits();
        test_long_one_bits();
        test_random_traffic();
        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d frames, %0d pixels dropped while busy, %0d busy and %0d idle ticks.",
                 frames_started, pixels_dropped, busy_ticks, idle_ticks);
        $display("Checked %0d result words, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/als_pkg.sv
rtl/als_front.sv
rtl/als_queue.sv
rtl/als_back.sv
rtl/addressable_led_serializer.sv
bench/tb_top.sv
